### hdl/grca_pkg.sv
// Package for the guest register cache allocator.
// Holds the table sizes, the allocation order and the mode, move and error codes.
// No dependencies.
package grca_pkg;

	localparam int GUEST_REGS_DEF = 32;
	localparam int HOST_REGS_DEF = 16;
	localparam int ORDER_LENGTH_DEF = 9;

	localparam logic [3:0] MODE_MAP = 4'd0;
	localparam logic [3:0] MODE_STORE = 4'd1;
	localparam logic [3:0] MODE_SETIMM = 4'd2;
	localparam logic [3:0] MODE_DISCARD = 4'd3;
	localparam logic [3:0] MODE_KILLIMM = 4'd4;
	localparam logic [3:0] MODE_FLUSH = 4'd5;
	localparam logic [3:0] MODE_LOCKGUEST = 4'd6;
	localparam logic [3:0] MODE_LOCKHOST = 4'd7;
	localparam logic [3:0] MODE_UNLOCKGUESTS = 4'd8;
	localparam logic [3:0] MODE_UNLOCKHOSTS = 4'd9;
	localparam logic [3:0] MODE_FLUSHHOST = 4'd10;
	localparam logic [3:0] MODE_QUERY = 4'd11;

	localparam logic [2:0] MOVE_NONE = 3'd0;
	localparam logic [2:0] MOVE_LOAD_SLOT = 3'd1;
	localparam logic [2:0] MOVE_LOAD_CONST = 3'd2;
	localparam logic [2:0] MOVE_STORE_HOST = 3'd3;
	localparam logic [2:0] MOVE_STORE_CONST = 3'd4;

	localparam logic [2:0] ERR_OK = 3'd0;
	localparam logic [2:0] ERR_OUT_OF_REGS = 3'd1;
	localparam logic [2:0] ERR_HOST_LOCKED = 3'd2;
	localparam logic [2:0] ERR_NO_HOST = 3'd3;
	localparam logic [2:0] ERR_LOCK_AT_FLUSH = 3'd4;

	localparam logic [1:0] LOC_SLOT = 2'd0;
	localparam logic [1:0] LOC_CONST = 2'd1;
	localparam logic [1:0] LOC_HOST = 2'd2;

	localparam logic [3:0] ALLOC_ORDER [16] = '{
		4'd6, 4'd7, 4'd13, 4'd14, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12,
		4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
	};

	typedef struct packed {
		logic [1:0] loc;
		logic [31:0] imm;
		logic [3:0] host;
	} guest_entry_t;

endpackage

### hdl/grca_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module grca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### hdl/guest_register_cache_allocator.sv
// Guest register cache allocator, top level.
// Uses grca_pkg and grca_ram for the guest table.
//
// Usage: one operation is a transfer on the input channel (mode, guest_reg,
// host_reg, imm_value, do_load, make_dirty). It yields zero or more move items
// on the output channel, then one status item with last set. Guest entries
// (location, constant, host index) live in a synchronous RAM with a registered
// read; guest lock bits and the host table are in flip-flops so that reset
// clears them at once. A guest entry that is not valid reads as in its slot.
// Simple modes go through the read, execute and status states. Map scans the
// allocation order one entry a cycle, first for a free host and then for one
// it may take or spill; a spill stores the old owner back before the load.
// Flush walks every guest entry in turn. Every move item holds the block
// until it is taken. One operation is handled at a time; the RAM port is the
// limiting resource. When the receiver stalls the block holds its result
// and waits. Reset empties all tables with no clearing pass.
module guest_register_cache_allocator #(
	parameter int GUEST_REGS = grca_pkg::GUEST_REGS_DEF,
	parameter int HOST_REGS = grca_pkg::HOST_REGS_DEF,
	parameter int ORDER_LENGTH = grca_pkg::ORDER_LENGTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [3:0] mode,
	input logic [4:0] guest_reg,
	input logic [3:0] host_reg,
	input logic [31:0] imm_value,
	input logic do_load,
	input logic make_dirty,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] move_kind,
	output logic [3:0] move_host,
	output logic [4:0] move_guest,
	output logic [31:0] value,
	output logic is_constant,
	output logic [2:0] error,
	output logic last
);
	import grca_pkg::*;

	localparam int GW = $clog2(GUEST_REGS);
	localparam int HW = $clog2(HOST_REGS);
	localparam int OW = $clog2(ORDER_LENGTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_READ, ST_EXEC, ST_SCAN_FREE, ST_SCAN_OWN, ST_SPILL_RD, ST_SPILL,
		ST_FLUSH_RD, ST_FLUSH, ST_EMIT, ST_STATUS, ST_MOVE_WAIT
	} state_t;

	state_t state_q, ret_q;
	logic [3:0] mode_q;
	logic [4:0] g_q;
	logic [3:0] h_q;
	logic [31:0] imm_q;
	logic load_q, dirty_q;
	logic [2:0] err_q;
	logic [OW-1:0] idx_q;
	logic [4:0] fidx_q;
	logic [3:0] alloc_q;
	guest_entry_t gent_q;

	logic [GUEST_REGS-1:0] gvalid_q, glock_q;
	logic [HOST_REGS-1:0] hfree_q, hdirty_q, hlock_q, howned_q;
	logic [4:0] howner_q [HOST_REGS];

	logic ram_we;
	logic [GW-1:0] ram_addr;
	guest_entry_t ram_wdata, ram_rdata, rd_ent;
	logic rd_valid_q;

	grca_ram #(.WIDTH($bits(guest_entry_t)), .DEPTH(GUEST_REGS)) u_gtab (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	assign rd_ent = rd_valid_q ? ram_rdata : '{loc: LOC_SLOT, imm: 32'd0, host: 4'd0};
	assign in_ready = (state_q == ST_IDLE);

	logic [3:0] oh;
	logic oh_ok;
	assign oh = ALLOC_ORDER[idx_q[3:0]];
	assign oh_ok = ({28'd0, oh} < HOST_REGS) && !hlock_q[oh[HW-1:0]];

	logic [4:0] fg;
	assign fg = fidx_q;

	always_comb begin
		ram_we = 1'b0;
		ram_addr = g_q[GW-1:0];
		ram_wdata = '{loc: LOC_SLOT, imm: 32'd0, host: 4'd0};
		case (state_q)
			ST_IDLE: ram_addr = guest_reg[GW-1:0];
			ST_SCAN_OWN: ram_addr = howner_q[oh[HW-1:0]][GW-1:0];
			ST_SPILL_RD, ST_SPILL: ram_addr = howner_q[alloc_q[HW-1:0]][GW-1:0];
			ST_FLUSH_RD, ST_FLUSH: ram_addr = fg[GW-1:0];
			default: ram_addr = g_q[GW-1:0];
		endcase
		if (state_q == ST_SPILL || state_q == ST_FLUSH) begin
			ram_we = 1'b1;
		end else if (state_q == ST_EMIT) begin
			ram_we = 1'b1;
			ram_wdata = '{loc: LOC_HOST, imm: 32'd0, host: alloc_q};
		end else if (state_q == ST_EXEC && {27'd0, g_q} < GUEST_REGS) begin
			case (mode_q)
				MODE_STORE: ram_we = 1'b1;
				MODE_DISCARD: begin
					ram_we = (rd_ent.loc == LOC_HOST);
					ram_wdata = rd_ent;
					ram_wdata.loc = (rd_ent.loc == LOC_HOST) ? LOC_SLOT : rd_ent.loc;
					ram_wdata.host = 4'd0;
				end
				MODE_SETIMM: begin
					ram_we = 1'b1;
					ram_wdata = '{loc: LOC_CONST, imm: (g_q == 5'd0) ? 32'd0 : imm_q,
						host: 4'd0};
				end
				default: ram_we = 1'b0;
			endcase
		end
	end

	task automatic put_move(input logic [2:0] k, input logic [3:0] hh, input logic [4:0] gg,
		input logic [31:0] v, input state_t nxt);
		begin
			out_valid <= 1'b1;
			move_kind <= k;
			move_host <= hh;
			move_guest <= gg;
			value <= v;
			is_constant <= 1'b0;
			error <= ERR_OK;
			last <= 1'b0;
			ret_q <= nxt;
			state_q <= ST_MOVE_WAIT;
		end
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			out_valid <= 1'b0;
			rd_valid_q <= 1'b0;
			gvalid_q <= '0;
			glock_q <= '0;
			hfree_q <= '1;
			hdirty_q <= '0;
			hlock_q <= '0;
			howned_q <= '0;
			for (int i = 0; i < HOST_REGS; i++) howner_q[i] <= 5'd0;
		end else begin
			rd_valid_q <= gvalid_q[ram_addr];
			if (ram_we) gvalid_q[ram_addr] <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						mode_q <= mode; g_q <= guest_reg; h_q <= host_reg; imm_q <= imm_value;
						load_q <= do_load; dirty_q <= make_dirty; err_q <= ERR_OK;
						idx_q <= '0; fidx_q <= 5'd0;
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_EXEC;
				ST_EXEC: begin
					state_q <= ST_STATUS;
					is_constant <= 1'b0;
					value <= 32'd0;
					if ({27'd0, g_q} < GUEST_REGS) begin
						case (mode_q)
							MODE_MAP, MODE_KILLIMM: begin
								if (rd_ent.loc == LOC_HOST) begin
									if (dirty_q) hdirty_q[rd_ent.host[HW-1:0]] <= 1'b1;
									if (mode_q == MODE_MAP && hlock_q[rd_ent.host[HW-1:0]])
										err_q <= ERR_HOST_LOCKED;
								end else if (mode_q == MODE_MAP || rd_ent.loc == LOC_CONST) begin
									gent_q <= rd_ent;
									state_q <= ST_SCAN_FREE;
								end
							end
							MODE_STORE: begin
								if (rd_ent.loc == LOC_HOST) begin
									hfree_q[rd_ent.host[HW-1:0]] <= 1'b1;
									hdirty_q[rd_ent.host[HW-1:0]] <= 1'b0;
									howned_q[rd_ent.host[HW-1:0]] <= 1'b0;
									howner_q[rd_ent.host[HW-1:0]] <= 5'd0;
									if (hdirty_q[rd_ent.host[HW-1:0]] && g_q != 5'd0)
										put_move(MOVE_STORE_HOST, rd_ent.host, g_q, 32'd0,
											ST_STATUS);
								end else if (rd_ent.loc == LOC_CONST && g_q != 5'd0)
									put_move(MOVE_STORE_CONST, 4'd0, g_q, rd_ent.imm, ST_STATUS);
							end
							MODE_SETIMM, MODE_DISCARD: begin
								if (rd_ent.loc == LOC_HOST) begin
									hfree_q[rd_ent.host[HW-1:0]] <= 1'b1;
									hdirty_q[rd_ent.host[HW-1:0]] <= 1'b0;
									howned_q[rd_ent.host[HW-1:0]] <= 1'b0;
									howner_q[rd_ent.host[HW-1:0]] <= 5'd0;
								end
							end
							MODE_LOCKGUEST: glock_q[g_q[GW-1:0]] <= 1'b1;
							MODE_QUERY: begin
								if (g_q == 5'd0) is_constant <= 1'b1;
								else if (rd_ent.loc == LOC_CONST) begin
									is_constant <= 1'b1;
									value <= rd_ent.imm;
								end
							end
							default: ;
						endcase
					end
					case (mode_q)
						MODE_FLUSH: begin
							if (|hlock_q || |glock_q) err_q <= ERR_LOCK_AT_FLUSH;
							state_q <= ST_FLUSH_RD;
						end
						MODE_LOCKHOST: begin
							if ({28'd0, h_q} >= HOST_REGS) err_q <= ERR_NO_HOST;
							else begin
								if (hlock_q[h_q[HW-1:0]]) err_q <= ERR_HOST_LOCKED;
								hlock_q[h_q[HW-1:0]] <= 1'b1;
							end
						end
						MODE_UNLOCKGUESTS: glock_q <= '0;
						MODE_UNLOCKHOSTS: hlock_q <= '0;
						MODE_FLUSHHOST: begin
							if ({28'd0, h_q} >= HOST_REGS) err_q <= ERR_NO_HOST;
							else if (!hfree_q[h_q[HW-1:0]] && howned_q[h_q[HW-1:0]]) begin
								fidx_q <= howner_q[h_q[HW-1:0]];
								state_q <= ST_FLUSH_RD;
							end
						end
						default: ;
					endcase
				end
				ST_SCAN_FREE: begin
					if ({{(32-OW){1'b0}}, idx_q} >= ORDER_LENGTH) begin
						idx_q <= '0;
						state_q <= ST_SCAN_OWN;
					end else if (oh_ok && hfree_q[oh[HW-1:0]]) begin
						alloc_q <= oh;
						state_q <= ST_EMIT;
					end else idx_q <= idx_q + 1'b1;
				end
				ST_SCAN_OWN: begin
					if ({{(32-OW){1'b0}}, idx_q} >= ORDER_LENGTH) begin
						err_q <= ERR_OUT_OF_REGS;
						state_q <= ST_STATUS;
					end else if (oh_ok && !howned_q[oh[HW-1:0]]) begin
						alloc_q <= oh;
						state_q <= ST_EMIT;
					end else if (oh_ok && !glock_q[howner_q[oh[HW-1:0]][GW-1:0]]) begin
						alloc_q <= oh;
						state_q <= ST_SPILL_RD;
					end else idx_q <= idx_q + 1'b1;
				end
				ST_SPILL_RD: state_q <= ST_SPILL;
				ST_SPILL, ST_FLUSH: begin
					if (state_q == ST_SPILL) ret_q <= ST_EMIT;
					else if (mode_q == MODE_FLUSH && {27'd0, fidx_q} < GUEST_REGS - 1)
						ret_q <= ST_FLUSH_RD;
					else ret_q <= ST_STATUS;
					state_q <= (state_q == ST_SPILL) ? ST_EMIT :
						((mode_q == MODE_FLUSH && {27'd0, fidx_q} < GUEST_REGS - 1)
						? ST_FLUSH_RD : ST_STATUS);
					if (state_q == ST_FLUSH) fidx_q <= fidx_q + 5'd1;
					if (rd_ent.loc == LOC_HOST) begin
						hfree_q[rd_ent.host[HW-1:0]] <= 1'b1;
						hdirty_q[rd_ent.host[HW-1:0]] <= 1'b0;
						howned_q[rd_ent.host[HW-1:0]] <= 1'b0;
						howner_q[rd_ent.host[HW-1:0]] <= 5'd0;
						if (hdirty_q[rd_ent.host[HW-1:0]] && ram_addr != '0)
							put_move(MOVE_STORE_HOST, rd_ent.host, 5'(ram_addr), 32'd0,
								(state_q == ST_SPILL) ? ST_EMIT :
								((mode_q == MODE_FLUSH && {27'd0, fidx_q} < GUEST_REGS - 1)
								? ST_FLUSH_RD : ST_STATUS));
					end else if (rd_ent.loc == LOC_CONST && ram_addr != '0)
						put_move(MOVE_STORE_CONST, 4'd0, 5'(ram_addr), rd_ent.imm,
							(state_q == ST_SPILL) ? ST_EMIT :
							((mode_q == MODE_FLUSH && {27'd0, fidx_q} < GUEST_REGS - 1)
							? ST_FLUSH_RD : ST_STATUS));
				end
				ST_FLUSH_RD: state_q <= ST_FLUSH;
				ST_EMIT: begin
					hfree_q[alloc_q[HW-1:0]] <= 1'b0;
					howned_q[alloc_q[HW-1:0]] <= 1'b1;
					howner_q[alloc_q[HW-1:0]] <= g_q;
					hdirty_q[alloc_q[HW-1:0]] <= dirty_q || gent_q.loc == LOC_CONST;
					state_q <= ST_STATUS;
					if (load_q) begin
						if (g_q == 5'd0)
							put_move(MOVE_LOAD_CONST, alloc_q, g_q, 32'd0, ST_STATUS);
						else if (gent_q.loc == LOC_CONST)
							put_move(MOVE_LOAD_CONST, alloc_q, g_q, gent_q.imm, ST_STATUS);
						else put_move(MOVE_LOAD_SLOT, alloc_q, g_q, 32'd0, ST_STATUS);
					end
				end
				ST_STATUS: begin
					out_valid <= 1'b1;
					move_kind <= MOVE_NONE;
					move_host <= 4'd0;
					move_guest <= 5'd0;
					error <= err_q;
					last <= 1'b1;
					if (mode_q != MODE_QUERY) begin
						value <= 32'd0;
						is_constant <= 1'b0;
					end
					ret_q <= ST_IDLE;
					state_q <= ST_MOVE_WAIT;
				end
				ST_MOVE_WAIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= ret_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(move_kind) && $stable(last)))
		else $error("result changed under stall");
	a_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (error == ERR_OK && move_kind != MOVE_NONE))
		else $error("bad move item");
`endif

endmodule

### bench/testbench.sv
// Self-checking bench for the guest register cache allocator.
// Holds a mapping predictor in a scoreboard class; depends on grca_pkg and the block.
`timescale 1ns / 1ps

module testbench;
	import grca_pkg::*;

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] host;
		logic [4:0] guest;
		logic [31:0] val;
		logic con;
		logic [2:0] err;
		logic lst;
	} move_t;

	class alloc_scoreboard;
		logic [1:0] g_loc [32];
		logic [31:0] g_imm [32];
		logic [3:0] g_host [32];
		bit g_lock [32];
		bit h_free [16];
		bit h_dirty [16];
		bit h_lock [16];
		bit h_owned [16];
		logic [4:0] h_owner [16];
		move_t pending [$];
		int mismatches;

		function new();
			for (int i = 0; i < 32; i++) begin
				g_loc[i] = LOC_SLOT;
				g_imm[i] = 0;
				g_host[i] = 0;
				g_lock[i] = 0;
			end
			for (int i = 0; i < 16; i++) begin
				h_free[i] = 1;
				h_dirty[i] = 0;
				h_lock[i] = 0;
				h_owned[i] = 0;
				h_owner[i] = 0;
			end
			mismatches = 0;
		endfunction

		function void emit(logic [2:0] k, logic [3:0] h, logic [4:0] g, logic [31:0] v,
			logic c, logic [2:0] e, logic l);
			move_t m;
			m.kind = k; m.host = h; m.guest = g; m.val = v; m.con = c; m.err = e; m.lst = l;
			pending.push_back(m);
		endfunction

		function void free_host(int h);
			h_free[h] = 1; h_dirty[h] = 0; h_owned[h] = 0; h_owner[h] = 0;
		endfunction

		function void spill_guest(int g);
			int h;
			bit wr;
			if (g_loc[g] == LOC_SLOT) return;
			if (g_loc[g] == LOC_HOST) begin
				h = g_host[g];
				wr = h_dirty[h];
				free_host(h);
				if (wr && g != 0) emit(MOVE_STORE_HOST, 4'(h), 5'(g), 0, 0, ERR_OK, 0);
			end else if (g != 0) begin
				emit(MOVE_STORE_CONST, 0, 5'(g), g_imm[g], 0, ERR_OK, 0);
			end
			g_loc[g] = LOC_SLOT; g_imm[g] = 0; g_host[g] = 0;
		endfunction

		function int pick_host();
			int h;
			for (int i = 0; i < ORDER_LENGTH_DEF; i++) begin
				h = ALLOC_ORDER[i];
				if (!h_lock[h] && h_free[h]) return h;
			end
			for (int i = 0; i < ORDER_LENGTH_DEF; i++) begin
				h = ALLOC_ORDER[i];
				if (h_lock[h]) continue;
				if (!h_owned[h]) return h;
				if (!g_lock[h_owner[h]]) begin
					spill_guest(h_owner[h]);
					return h;
				end
			end
			return -1;
		endfunction

		function logic [2:0] bind_guest(int g, bit ld, bit dirty);
			int h;
			if (g_loc[g] == LOC_HOST) begin
				h = g_host[g];
				if (dirty) h_dirty[h] = 1;
				return h_lock[h] ? ERR_HOST_LOCKED : ERR_OK;
			end
			h = pick_host();
			if (h < 0) return ERR_OUT_OF_REGS;
			h_free[h] = 0; h_owned[h] = 1; h_owner[h] = 5'(g);
			h_dirty[h] = dirty || g_loc[g] == LOC_CONST;
			if (ld) begin
				if (g == 0) emit(MOVE_LOAD_CONST, 4'(h), 5'(g), 0, 0, ERR_OK, 0);
				else if (g_loc[g] == LOC_CONST)
					emit(MOVE_LOAD_CONST, 4'(h), 5'(g), g_imm[g], 0, ERR_OK, 0);
				else emit(MOVE_LOAD_SLOT, 4'(h), 5'(g), 0, 0, ERR_OK, 0);
			end
			g_loc[g] = LOC_HOST; g_imm[g] = 0; g_host[g] = 4'(h);
			return ERR_OK;
		endfunction

		function void drop_guest(int g);
			if (g_loc[g] == LOC_HOST) begin
				free_host(g_host[g]);
				g_loc[g] = LOC_SLOT; g_host[g] = 0;
			end
		endfunction

		function void note_input(logic [3:0] md, logic [4:0] g, logic [3:0] h, logic [31:0] imm,
			bit ld, bit dirty);
			logic [2:0] e;
			logic [31:0] qv;
			bit qc;
			e = ERR_OK; qv = 0; qc = 0;
			case (md)
				MODE_MAP: e = bind_guest(g, ld, dirty);
				MODE_STORE: spill_guest(g);
				MODE_SETIMM: begin
					drop_guest(g);
					g_loc[g] = LOC_CONST; g_imm[g] = (g == 0) ? 0 : imm; g_host[g] = 0;
				end
				MODE_DISCARD: drop_guest(g);
				MODE_KILLIMM: begin
					if (g_loc[g] == LOC_CONST) e = bind_guest(g, ld, dirty);
					else if (g_loc[g] == LOC_HOST && dirty) h_dirty[g_host[g]] = 1;
				end
				MODE_FLUSH: begin
					for (int i = 0; i < 16; i++) if (h_lock[i]) e = ERR_LOCK_AT_FLUSH;
					for (int i = 0; i < 32; i++) begin
						if (g_lock[i]) e = ERR_LOCK_AT_FLUSH;
						spill_guest(i);
					end
				end
				MODE_LOCKGUEST: g_lock[g] = 1;
				MODE_LOCKHOST: begin
					if (h_lock[h]) e = ERR_HOST_LOCKED;
					h_lock[h] = 1;
				end
				MODE_UNLOCKGUESTS: for (int i = 0; i < 32; i++) g_lock[i] = 0;
				MODE_UNLOCKHOSTS: for (int i = 0; i < 16; i++) h_lock[i] = 0;
				MODE_FLUSHHOST: if (!h_free[h] && h_owned[h]) spill_guest(h_owner[h]);
				MODE_QUERY: begin
					if (g == 0) qc = 1;
					else if (g_loc[g] == LOC_CONST) begin
						qc = 1; qv = g_imm[g];
					end
				end
				default: ;
			endcase
			emit(MOVE_NONE, 0, 0, qv, qc, e, 1);
		endfunction

		function void check_result(move_t got);
			move_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: expected %h, got %h", want, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [3:0] mode = 0;
	logic [4:0] guest_reg = 0;
	logic [3:0] host_reg = 0;
	logic [31:0] imm_value = 0;
	logic do_load = 0;
	logic make_dirty = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [2:0] move_kind;
	logic [3:0] move_host;
	logic [4:0] move_guest;
	logic [31:0] value;
	logic is_constant;
	logic [2:0] error;
	logic last;

	int send_idle = 0;
	int recv_stall = 0;
	int quiet = 0;
	alloc_scoreboard sb = new();

	always #1 clk = ~clk;

	guest_register_cache_allocator uut (.*);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({move_kind, move_host, move_guest, value, is_constant, error, last});
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall);

	task automatic send_op(logic [3:0] md, logic [4:0] g, logic [3:0] h, logic [31:0] imm,
		bit ld, bit dirty);
		while ($urandom_range(99) < send_idle) @(negedge clk);
		in_valid <= 1; mode <= md; guest_reg <= g; host_reg <= h;
		imm_value <= imm; do_load <= ld; make_dirty <= dirty;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(md, g, h, imm, ld, dirty);
		@(negedge clk);
		in_valid <= 0;
		@(negedge clk);
	endtask

	task automatic send_random();
		int r;
		logic [3:0] md;
		r = $urandom_range(99);
		if (r < 40) md = MODE_MAP;
		else if (r < 47) md = MODE_SETIMM;
		else if (r < 52) md = MODE_KILLIMM;
		else if (r < 95) md = 4'($urandom_range(15));
		else md = MODE_FLUSH;
		send_op(md, 5'(($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(12)),
			4'($urandom_range(15)), $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		send_op(MODE_QUERY, 0, 0, 0, 0, 0);
		send_op(MODE_SETIMM, 31, 0, 32'hFFFF_FFFF, 0, 0);
		send_op(MODE_SETIMM, 0, 0, 32'h1234_5678, 0, 0);
		send_op(MODE_QUERY, 31, 0, 0, 0, 0);
		send_op(MODE_QUERY, 5, 0, 0, 0, 0);
		send_op(MODE_KILLIMM, 31, 0, 0, 1, 0);
		for (int g = 1; g <= 10; g++) send_op(MODE_MAP, 5'(g), 0, 0, 1, g[0]);
		send_op(MODE_MAP, 0, 0, 0, 1, 1);
		send_op(MODE_LOCKHOST, 0, 15, 0, 0, 0);
		send_op(MODE_LOCKHOST, 0, 15, 0, 0, 0);
		send_op(MODE_LOCKGUEST, 3, 0, 0, 0, 0);
		send_op(MODE_FLUSHHOST, 0, 6, 0, 0, 0);
		send_op(MODE_STORE, 4, 0, 0, 0, 0);
		send_op(MODE_DISCARD, 5, 0, 0, 0, 0);
		for (int i = 6; i < 16; i++) send_op(MODE_LOCKHOST, 0, 4'(i), 0, 0, 0);
		send_op(MODE_MAP, 20, 0, 0, 1, 0);
		send_op(MODE_MAP, 3, 0, 0, 0, 1);
		send_op(MODE_FLUSH, 0, 0, 0, 0, 0);
		send_op(4'd15, 0, 0, 0, 0, 0);
		send_op(MODE_UNLOCKGUESTS, 0, 0, 0, 0, 0);
		send_op(MODE_UNLOCKHOSTS, 0, 0, 0, 0, 0);
		drain();
		for (int p = 0; p < 4; p++) begin
			send_idle = (p == 1 || p == 3) ? ((p == 3) ? 12 : 56) : 0;
			recv_stall = (p == 2) ? 56 : ((p == 3) ? 12 : 0);
			for (int n = 0; n < 36; n++) send_random();
			drain();
		end
		recv_stall = 0;
		drain();
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### files.f
hdl/grca_pkg.sv
hdl/grca_ram.sv
hdl/guest_register_cache_allocator.sv
bench/testbench.sv
